[design/aes_pkg.sv]
package aes_pkg;

  localparam int NUM_ROUNDS = 10;
  localparam logic [7:0] GF_REDUCE = 8'h1B;
  localparam logic [7:0] GF_TOPBIT = 8'h80;

  typedef struct packed {
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
  } aes_out_t;

  // State and round key moving down the chain; byte n sits in bits 127-8n -: 8.
  typedef struct packed {
    logic [127:0] state;
    logic [127:0] rkey;
  } aes_lane_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    logic [7:0] r;
    r = {v[6:0], 1'b0};
    if ((v & GF_TOPBIT) != 8'h00) begin
      r = r ^ GF_REDUCE;
    end
    return r;
  endfunction

  // Round constant for round rnd (1-based): 0x01 doubled rnd-1 times.
  function automatic logic [7:0] rcon_at(input int rnd);
    logic [7:0] r;
    r = 8'h01;
    for (int k = 1; k < rnd; k++) begin
      r = gf_double(r);
    end
    return r;
  endfunction

endpackage

[design/aes128_block_encrypt.sv]
// AES-128 encryption engine, one block per transfer.
//
// Input channel (in_valid / in_ready / in_data): each transfer carries a
// 128-bit key and a 128-bit plaintext block, both as high and low halves with
// byte 0 in the top bits of the high half. Output channel (out_valid /
// out_ready / out_data) returns the ciphertext for every input, in order.
//
// The data path is a chain of ten round cells, one per AES round. The initial
// key addition sits in front of the first cell; each cell does ShiftRows,
// SubBytes, MixColumns (skipped in the last cell) and expands its own round
// key from the one handed in by its neighbor. The last cell's register is the
// output register.
//
// A block is registered in each cell in turn before out_valid rises. Throughput:
// one block per cycle, one round per cell per cycle, while out_ready stays high.
// Each cell takes new data whenever it is empty or its successor takes its
// contents, so bubbles collapse and input keeps flowing while a result waits.
// When the receiver stalls, the chain fills up and in_ready falls after the
// cells are full. Reset empties all cells; payload registers are not reset.
module aes128_block_encrypt import aes_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  aes_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output aes_out_t out_data
);

  logic      stg_valid [NUM_ROUNDS + 1];
  logic      stg_ready [NUM_ROUNDS + 1];
  aes_lane_t stg_lane  [NUM_ROUNDS + 1];

  // Front of the chain: initial round-key addition.
  assign stg_valid[0]      = in_valid;
  assign in_ready          = stg_ready[0];
  assign stg_lane[0].rkey  = {in_data.key_hi, in_data.key_lo};
  assign stg_lane[0].state = {in_data.block_hi, in_data.block_lo}
                             ^ {in_data.key_hi, in_data.key_lo};

  for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_round
    aes_round_cell #(
      .RCON (rcon_at(i + 1)),
      .LAST (i == NUM_ROUNDS - 1)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[i]),
      .up_ready (stg_ready[i]),
      .up_lane  (stg_lane[i]),
      .dn_valid (stg_valid[i + 1]),
      .dn_ready (stg_ready[i + 1]),
      .dn_lane  (stg_lane[i + 1])
    );
  end

  // Tail of the chain drives the result channel.
  assign out_valid                = stg_valid[NUM_ROUNDS];
  assign stg_ready[NUM_ROUNDS]    = out_ready;
  assign out_data.cipher_hi       = stg_lane[NUM_ROUNDS].state[127:64];
  assign out_data.cipher_lo       = stg_lane[NUM_ROUNDS].state[63:0];

endmodule

[design/aes_round_cell.sv]
module aes_round_cell import aes_pkg::*; #(
  parameter logic [7:0] RCON    = 8'h01,
  parameter bit         LAST    = 1'b0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  aes_lane_t up_lane,
  output logic      dn_valid,
  input  logic      dn_ready,
  output aes_lane_t dn_lane
);

  logic      valid_r, valid_nxt;
  aes_lane_t lane_r, lane_nxt;
  logic      load;

  logic [7:0]   s [16];
  logic [7:0]   t [16];
  logic [7:0]   m [16];
  logic [7:0]   k [16];
  logic [31:0]  w0, w1, w2, w3;
  logic [127:0] new_key;
  logic [127:0] mixed;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    for (int n = 0; n < 16; n++) begin
      s[n] = up_lane.state[127 - 8*n -: 8];
      k[n] = up_lane.rkey[127 - 8*n -: 8];
    end
    // shift rows and substitute
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = sbox(s[r + 4*((c + r) % 4)]);
      end
    end
    // mix columns
    for (int c = 0; c < 4; c++) begin
      logic [7:0] all;
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ all ^ gf_double(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ all ^ gf_double(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ all ^ gf_double(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ all ^ gf_double(t[4*c+3] ^ t[4*c]);
    end
    for (int n = 0; n < 16; n++) begin
      mixed[127 - 8*n -: 8] = LAST ? t[n] : m[n];
    end
  end

  // key schedule: rotate, substitute, add round constant, then ripple the words
  always_comb begin
    w0 = up_lane.rkey[127:96] ^ {sbox(k[13]) ^ RCON, sbox(k[14]), sbox(k[15]), sbox(k[12])};
    w1 = up_lane.rkey[95:64] ^ w0;
    w2 = up_lane.rkey[63:32] ^ w1;
    w3 = up_lane.rkey[31:0]  ^ w2;
    new_key = {w0, w1, w2, w3};
  end

  always_comb begin
    lane_nxt.rkey  = new_key;
    lane_nxt.state = mixed ^ new_key;
    if (load) begin
      valid_nxt = 1'b1;
    end else begin
      valid_nxt = valid_r && !dn_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lane_r <= lane_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_lane  = lane_r;

endmodule

[test/aes128_block_encrypt_tb.sv]
module aes128_block_encrypt_tb import aes_pkg::*; ();

  localparam int ROUND_COUNT = 10;   // AES-128 rounds
  localparam int PIPE_DEPTH = 10;    // round cells between input and output
  localparam int RANDOM_ITEMS = 950;
  localparam int IDLE_PCT = 26;      // chance per cycle that a side idles
  localparam int STEADY_FROM = 300;  // random items in [STEADY_FROM, STEADY_TO) run without gaps
  localparam int STEADY_TO = 450;
  localparam int HOLD_AT = 600;      // accepted blocks before the long output stall
  localparam int HOLD_CYCLES = 60;
  localparam int QUIET_LIMIT = 1000; // cycles without any transfer before giving up

  // One directed vector: block and key, plus the ciphertext where it is
  // a published value; rows with known = 0 go through the local cipher.
  typedef struct packed {
    logic     known;
    aes_in_t  blk;
    aes_out_t cipher;
  } vector_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  aes_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  aes_out_t out_data;

  logic [7:0] sub_lut [256];  // S-box, built from the field inverse at time zero
  aes_out_t   cipher_due [$]; // ciphertexts owed by the block, oldest first
  int         accepted = 0;
  int         checked = 0;
  int         errors = 0;
  int         quiet_cycles = 0;
  bit         steady = 1'b0;
  bit         held_off = 1'b0;

  vector_row_t vectors [13] = '{
    // FIPS-197 example cipher, sequential key
    '{1'b1, '{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
              64'h0011223344556677, 64'h8899aabbccddeeff},
            '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a}},
    // FIPS-197 worked example
    '{1'b1, '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
              64'h3243f6a8885a308d, 64'h313198a2e0370734},
            '{64'h3925841d02dc09fb, 64'hdc118597196a0b32}},
    // all-zero key and block
    '{1'b1, '{64'h0, 64'h0, 64'h0, 64'h0},
            '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e}},
    // ECB example block one
    '{1'b1, '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
              64'h6bc1bee22e409f96, 64'he93d7e117393172a},
            '{64'h3ad77bb40d7a3660, 64'ha89ecaf32466ef97}},
    // extremes of each half, alternating patterns, lone bits at both ends
    '{1'b0, '{64'h0, 64'h0, '1, '1}, '0},
    '{1'b0, '{'1, '1, 64'h0, 64'h0}, '0},
    '{1'b0, '{'1, '1, '1, '1}, '0},
    '{1'b0, '{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
              64'haaaaaaaaaaaaaaaa, 64'h5555555555555555}, '0},
    '{1'b0, '{64'h0, 64'h1, 64'h0, 64'h1}, '0},
    '{1'b0, '{64'h8000000000000000, 64'h0, 64'h8000000000000000, 64'h0}, '0},
    '{1'b0, '{64'h0, '1, '1, 64'h0}, '0},
    '{1'b0, '{'1, 64'h0, 64'h0, '1}, '0},
    '{1'b0, '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 64'h0, 64'h0}, '0}
  };

  aes128_block_encrypt dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Multiply by x in GF(2^8), AES polynomial.
  function automatic logic [7:0] times_x(input logic [7:0] v);
    return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        p = p ^ a;
      end
      a = times_x(a);
    end
    return p;
  endfunction

  // Fill the S-box: multiplicative inverse (zero maps to zero), then the
  // affine map b ^ rotl1 ^ rotl2 ^ rotl3 ^ rotl4 ^ 0x63.
  function automatic void build_sub_lut();
    logic [7:0] inv;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++) begin
        if (x != 0 && gf_mul(x[7:0], y[7:0]) == 8'h01) begin
          inv = y[7:0];
        end
      end
      s = inv ^ 8'h63;
      for (int k = 1; k <= 4; k++) begin
        s = s ^ ((inv << k) | (inv >> (8 - k)));
      end
      sub_lut[x] = s;
    end
  endfunction

  // AES-128 on one transfer. State bytes are column-major: byte n is row
  // n%4 of column n/4, byte 0 in the top bits of the high half.
  function automatic aes_out_t encrypt_block(input aes_in_t d);
    logic [127:0] kv;
    logic [127:0] pv;
    logic [127:0] cv;
    logic [7:0]   rk [16];
    logic [7:0]   st [16];
    logic [7:0]   t [16];
    logic [7:0]   rc;
    logic [7:0]   a0, a1, a2, a3, all;
    aes_out_t     res;
    kv = {d.key_hi, d.key_lo};
    pv = {d.block_hi, d.block_lo};
    for (int n = 0; n < 16; n++) begin
      rk[n] = kv[127 - 8 * n -: 8];
      st[n] = pv[127 - 8 * n -: 8] ^ rk[n];
    end
    rc = 8'h01;
    for (int rnd = 1; rnd <= ROUND_COUNT; rnd++) begin
      // SubBytes and ShiftRows together: row r rotates left by r columns
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          t[r + 4 * c] = sub_lut[st[r + 4 * ((c + r) % 4)]];
        end
      end
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c];
        a1 = t[4 * c + 1];
        a2 = t[4 * c + 2];
        a3 = t[4 * c + 3];
        if (rnd < ROUND_COUNT) begin
          all = a0 ^ a1 ^ a2 ^ a3;
          a0 = t[4 * c] ^ all ^ times_x(t[4 * c] ^ t[4 * c + 1]);
          a1 = t[4 * c + 1] ^ all ^ times_x(t[4 * c + 1] ^ t[4 * c + 2]);
          a2 = t[4 * c + 2] ^ all ^ times_x(t[4 * c + 2] ^ t[4 * c + 3]);
          a3 = t[4 * c + 3] ^ all ^ times_x(t[4 * c + 3] ^ t[4 * c]);
        end
        st[4 * c] = a0;
        st[4 * c + 1] = a1;
        st[4 * c + 2] = a2;
        st[4 * c + 3] = a3;
      end
      // next round key: RotWord, SubWord and rcon on the last word, then chain
      rk[0] = rk[0] ^ sub_lut[rk[13]] ^ rc;
      rk[1] = rk[1] ^ sub_lut[rk[14]];
      rk[2] = rk[2] ^ sub_lut[rk[15]];
      rk[3] = rk[3] ^ sub_lut[rk[12]];
      for (int n = 4; n < 16; n++) begin
        rk[n] = rk[n] ^ rk[n - 4];
      end
      rc = times_x(rc);
      for (int n = 0; n < 16; n++) begin
        st[n] = st[n] ^ rk[n];
      end
    end
    for (int n = 0; n < 16; n++) begin
      cv[127 - 8 * n -: 8] = st[n];
    end
    res.cipher_hi = cv[127:64];
    res.cipher_lo = cv[63:0];
    return res;
  endfunction

  // Random 64-bit half, biased toward all zeros, all ones and lone bits.
  function automatic logic [63:0] pick_half();
    logic [63:0] v;
    int          sel;
    sel = $urandom_range(99);
    v = {$urandom, $urandom};
    if (sel < 8) begin
      v = '0;
    end else if (sel < 16) begin
      v = '1;
    end else if (sel < 22) begin
      v = 64'h1 << $urandom_range(63);
    end
    return v;
  endfunction

  // Offer one block, idling a cycle at a time at random first, and hold it
  // until the transfer; record its ciphertext at the accepting edge. Call
  // only at a rising edge.
  task automatic offer_block(input aes_in_t blk, input aes_out_t cipher);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= blk;
    do @(posedge clk); while (!in_ready);
    cipher_due.push_back(cipher);
    accepted++;
  endtask

  // Stimulus: directed vectors, then random blocks with occasional key reuse.
  initial begin : stimulus
    aes_in_t blk;
    build_sub_lut();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < $size(vectors); i++) begin
      offer_block(vectors[i].blk,
                  vectors[i].known ? vectors[i].cipher : encrypt_block(vectors[i].blk));
    end
    blk = vectors[$size(vectors) - 1].blk;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= STEADY_FROM && i < STEADY_TO);
      // keep the previous key now and then: nothing may carry over between blocks
      if ($urandom_range(99) >= 20) begin
        blk.key_hi = pick_half();
        blk.key_lo = pick_half();
      end
      blk.block_hi = pick_half();
      blk.block_lo = pick_half();
      offer_block(blk, encrypt_block(blk));
    end
    in_valid <= 1'b0;
    steady = 1'b0;
    // drain, then give the chain time to show any stray result
    while (cipher_due.size() != 0) @(posedge clk);
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    $display("%0d blocks encrypted (%0d directed, %0d random), %0d ciphertexts checked,",
             accepted, $size(vectors), RANDOM_ITEMS, checked);
    $display("gapped and gap-free traffic, one %0d-cycle output stall; %0d errors",
             HOLD_CYCLES, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: random stalls, none while the steady stretch runs, and
  // one long hold-off once enough blocks have gone in to fill the chain.
  initial begin : result_sink
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!held_off && accepted >= HOLD_AT) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Check every output transfer against the oldest owed ciphertext.
  always @(posedge clk) begin
    aes_out_t due;
    if (rst_n && out_valid && out_ready) begin
      if (cipher_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h_%h", $time, out_data.cipher_hi,
                 out_data.cipher_lo);
      end else begin
        due = cipher_due.pop_front();
        checked++;
        if (out_data.cipher_hi !== due.cipher_hi) begin
          errors++;
          $display("%0t: cipher_hi expected %h got %h", $time, due.cipher_hi,
                   out_data.cipher_hi);
        end
        if (out_data.cipher_lo !== due.cipher_lo) begin
          errors++;
          $display("%0t: cipher_lo expected %h got %h", $time, due.cipher_lo,
                   out_data.cipher_lo);
        end
      end
    end
  end

  // Watchdog: drop the run if neither channel transfers for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                 quiet_cycles, cipher_due.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
design/aes_pkg.sv
design/aes_round_cell.sv
design/aes128_block_encrypt.sv
test/aes128_block_encrypt_tb.sv
